// ===== rtl/gbga_pkg.sv =====
// ----------------------------------------------------------------------------
// gbga_pkg
// Shared types and constants for the GB2312 text to glyph address block.
// ----------------------------------------------------------------------------
package gbga_pkg;

  // Character code ranges.
  localparam logic [7:0] HANZI_LEAD_LO = 8'hB0;
  localparam logic [7:0] HANZI_LEAD_HI = 8'hF7;
  localparam logic [7:0] SYM_LEAD_LO   = 8'hA1;
  localparam logic [7:0] SYM_LEAD_HI   = 8'hA3;
  localparam logic [7:0] TRAIL_LO      = 8'hA1;
  localparam logic [7:0] ASCII_LO      = 8'h20;
  localparam logic [7:0] ASCII_HI      = 8'h7E;

  // Font ROM layout.
  localparam logic [6:0]  ROW_CELLS       = 7'd94;
  localparam logic [12:0] HANZI_BASE_CELL = 13'd846;
  localparam logic [17:0] BASE_8X16       = 18'h3CF80;
  localparam logic [17:0] BASE_5X8        = 18'h3BFC0;

  // Column advance per glyph kind.
  localparam logic [7:0] ADV_16X16 = 8'd16;
  localparam logic [7:0] ADV_8X16  = 8'd8;
  localparam logic [7:0] ADV_5X8   = 8'd6;

  // Glyph kind codes.
  localparam logic [1:0] KIND_16X16 = 2'd0;
  localparam logic [1:0] KIND_8X16  = 2'd1;
  localparam logic [1:0] KIND_5X8   = 2'd2;

  // Font mode codes.
  localparam logic MODE_MIXED = 1'b0;
  localparam logic MODE_SMALL = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_start;
    logic [3:0] start_page;
    logic [7:0] start_column;
  } item_t;

  typedef struct packed {
    logic [17:0] glyph_address;
    logic [1:0]  glyph_kind;
    logic [3:0]  draw_page;
    logic [7:0]  draw_column;
  } result_t;

  typedef struct packed {
    logic [7:0] held_lead;
    logic       lead_waiting;
    logic [7:0] current_column;
    logic [3:0] current_page;
    logic       string_open;
  } state_t;

endpackage

// ===== rtl/gbga_if.sv =====
// ----------------------------------------------------------------------------
// gbga_in_if / gbga_out_if
// Valid/ready channels carrying text requests in and glyph requests out.
// ----------------------------------------------------------------------------
interface gbga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       string_start;
  logic [3:0] start_page;
  logic [7:0] start_column;

  modport source (output valid, output text_byte, output string_start,
                  output start_page, output start_column, input ready);
  modport sink   (input valid, input text_byte, input string_start,
                  input start_page, input start_column, output ready);
endinterface

interface gbga_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] glyph_address;
  logic [1:0]  glyph_kind;
  logic [3:0]  draw_page;
  logic [7:0]  draw_column;

  modport source (output valid, output glyph_address, output glyph_kind,
                  output draw_page, output draw_column, input ready);
  modport sink   (input valid, input glyph_address, input glyph_kind,
                  input draw_page, input draw_column, output ready);
endinterface

// ===== rtl/gbga_decode.sv =====
// ----------------------------------------------------------------------------
// gbga_decode
// Decodes one text byte against the current string state: gives the next
// state and, for a drawable character, the glyph request.
// ----------------------------------------------------------------------------
module gbga_decode (
  input  gbga_pkg::item_t   item,
  input  gbga_pkg::state_t  state_cur,
  input  logic              font_mode,
  output gbga_pkg::state_t  state_nxt,
  output logic              emit,
  output gbga_pkg::result_t result
);
  import gbga_pkg::*;

  logic [7:0]  b;
  logic        is_ascii;
  logic        is_hanzi_lead;
  logic        is_sym_lead;
  logic        is_trail;
  logic [6:0]  ascii_off;
  logic [6:0]  row;
  logic [12:0] row_base;
  logic [12:0] cell_idx;
  logic        held_hanzi;

  // Byte classification.
  assign b             = item.text_byte;
  assign is_ascii      = (b >= ASCII_LO) && (b <= ASCII_HI);
  assign is_hanzi_lead = (b >= HANZI_LEAD_LO) && (b <= HANZI_LEAD_HI);
  assign is_sym_lead   = (b >= SYM_LEAD_LO) && (b <= SYM_LEAD_HI);
  assign is_trail      = (b >= TRAIL_LO);
  assign ascii_off     = 7'(b - ASCII_LO);

  // Double-byte cell number from the held lead and this trail.
  assign held_hanzi = (state_cur.held_lead >= HANZI_LEAD_LO);
  assign row        = held_hanzi ? 7'(state_cur.held_lead - HANZI_LEAD_LO)
                                 : 7'(state_cur.held_lead - SYM_LEAD_LO);
  assign row_base   = 13'(row * ROW_CELLS);
  assign cell_idx   = row_base + 13'(7'(b - TRAIL_LO))
                      + (held_hanzi ? HANZI_BASE_CELL : 13'd0);

  // Sequence handling for one byte.
  always_comb begin
    logic [7:0] advance;
    logic       taken;
    state_nxt = state_cur;
    emit      = 1'b0;
    advance   = 8'd0;
    taken     = 1'b0;
    result.glyph_address = 18'd0;
    result.glyph_kind    = KIND_16X16;

    if (item.string_start) begin
      state_nxt.current_page   = item.start_page;
      state_nxt.current_column = item.start_column;
      state_nxt.string_open    = 1'b1;
      state_nxt.lead_waiting   = 1'b0;
      state_nxt.held_lead      = 8'd0;
    end

    result.draw_page   = state_nxt.current_page;
    result.draw_column = state_nxt.current_column;

    if (state_nxt.string_open) begin
      if (b == 8'd0) begin
        state_nxt.string_open  = 1'b0;
        state_nxt.lead_waiting = 1'b0;
        state_nxt.held_lead    = 8'd0;
      end else if (font_mode == MODE_SMALL) begin
        state_nxt.lead_waiting = 1'b0;
        if (is_ascii) begin
          emit                 = 1'b1;
          advance              = ADV_5X8;
          result.glyph_kind    = KIND_5X8;
          result.glyph_address = BASE_5X8 + {8'd0, ascii_off, 3'd0};
        end
      end else begin
        // A waiting lead pairs with a trail, or is dropped.
        if (state_nxt.lead_waiting) begin
          state_nxt.lead_waiting = 1'b0;
          if (is_trail) begin
            taken                = 1'b1;
            emit                 = 1'b1;
            advance              = ADV_16X16;
            result.glyph_kind    = KIND_16X16;
            result.glyph_address = {cell_idx, 5'd0};
          end
        end
        if (!taken) begin
          if (is_hanzi_lead || is_sym_lead) begin
            state_nxt.held_lead    = b;
            state_nxt.lead_waiting = 1'b1;
          end else if (is_ascii) begin
            emit                 = 1'b1;
            advance              = ADV_8X16;
            result.glyph_kind    = KIND_8X16;
            result.glyph_address = BASE_8X16 + {7'd0, ascii_off, 4'd0};
          end
        end
      end
    end

    state_nxt.current_column = state_nxt.current_column + advance;
  end

endmodule

// ===== rtl/gbga_out_queue.sv =====
// ----------------------------------------------------------------------------
// gbga_out_queue
// Two-entry output buffer: a head register feeding the port and a skid
// register behind it, so the decode stage never waits on the sink directly.
// ----------------------------------------------------------------------------
module gbga_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gbga_pkg::result_t push_data,
  output logic              full,
  gbga_out_if.source        out_chan
);
  import gbga_pkg::*;

  result_t    head_r;
  result_t    skid_r;
  logic [1:0] count_r;
  logic       pop;

  assign full = (count_r == 2'd2);
  assign pop  = out_chan.valid && out_chan.ready;

  assign out_chan.valid         = (count_r != 2'd0);
  assign out_chan.glyph_address = head_r.glyph_address;
  assign out_chan.glyph_kind    = head_r.glyph_kind;
  assign out_chan.draw_page     = head_r.draw_page;
  assign out_chan.draw_column   = head_r.draw_column;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else if (push && !pop) begin
      count_r <= count_r + 2'd1;
    end else if (pop && !push) begin
      count_r <= count_r - 2'd1;
    end
  end

  // Payload movement; the head always holds the oldest request.
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count_r == 2'd2) begin
        head_r <= skid_r;
        skid_r <= push_data;
      end else begin
        head_r <= push_data;
      end
    end else if (push) begin
      if (count_r == 2'd0) begin
        head_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end else if (pop) begin
      head_r <= skid_r;
    end
  end

endmodule

// ===== rtl/gb2312_text_to_glyph_address.sv =====
// ----------------------------------------------------------------------------
// gb2312_text_to_glyph_address
// Turns a text byte stream into font ROM glyph addresses with draw positions.
// ----------------------------------------------------------------------------
// An accepted request passes through the input register, then decode feeds
// straight into the output buffer, whose head drives the glyph request port.
// Throughput: one text byte per cycle while the output buffer is not full.
// Reset (rst_n low, synchronous) empties the pipeline, closes the string,
// clears position and lead state, and selects mixed mode.
// ----------------------------------------------------------------------------
module gb2312_text_to_glyph_address (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  gbga_in_if.sink    in_chan,
  gbga_out_if.source out_chan
);
  import gbga_pkg::*;

  logic    font_mode_r;
  logic    s1_valid_r;
  item_t   s1_item_r;
  state_t  state_r;
  state_t  state_nxt;
  logic    s1_adv;
  logic    emit;
  result_t result;
  logic    q_full;
  logic    push;
  item_t   in_item;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_mode_r <= MODE_MIXED;
    end else if (cfg_we) begin
      font_mode_r <= cfg_wdata;
    end
  end

  // Input register.
  assign in_item.text_byte    = in_chan.text_byte;
  assign in_item.string_start = in_chan.string_start;
  assign in_item.start_page   = in_chan.start_page;
  assign in_item.start_column = in_chan.start_column;

  assign s1_adv        = s1_valid_r && !q_full;
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_item_r <= in_item;
    end
  end

  // Decode stage.
  gbga_decode u_decode (
    .item      (s1_item_r),
    .state_cur (state_r),
    .font_mode (font_mode_r),
    .state_nxt (state_nxt),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Output buffer.
  assign push = s1_adv && emit;

  gbga_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (result),
    .full      (q_full),
    .out_chan  (out_chan)
  );

  // Checks.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full)) else $error("glyph request pushed into a full buffer");

  a_closed_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !state_r.string_open && !s1_item_r.string_start) |-> !emit)
    else $error("glyph request from a closed string");

  a_lead_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.lead_waiting |->
      ((state_r.held_lead >= HANZI_LEAD_LO && state_r.held_lead <= HANZI_LEAD_HI) ||
       (state_r.held_lead >= SYM_LEAD_LO && state_r.held_lead <= SYM_LEAD_HI)))
    else $error("waiting lead byte outside lead ranges");

  a_small_no_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && font_mode_r == MODE_SMALL) |=> !state_r.lead_waiting)
    else $error("lead byte held in small mode");

endmodule
